@@ src/imse_pkg.sv @@
`default_nettype none
package imse_pkg;

  localparam int MsgBytesDefault   = 32;
  localparam int QueueDepthDefault = 4;

  localparam logic [7:0] CrcPoly    = 8'h07;
  localparam logic [7:0] CmdPoll    = 8'h01;
  localparam logic [7:0] CmdDeliver = 8'h10;
  localparam logic [7:0] CmdAck     = 8'h20;
  localparam logic [7:0] AckGood    = 8'h01;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_HOST  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    PEND_NONE    = 2'd0,
    PEND_POLL    = 2'd1,
    PEND_DELIVER = 2'd2,
    PEND_ACK     = 2'd3
  } pend_e;

  typedef enum logic [3:0] {
    EV_READ    = 4'd0,
    EV_DELIV   = 4'd1,
    EV_ACKOK   = 4'd2,
    EV_NACK    = 4'd3,
    EV_CRCERR  = 4'd4,
    EV_IGNORED = 4'd5,
    EV_ACCEPT  = 4'd6,
    EV_REJECT  = 4'd7,
    EV_TAKEN   = 4'd8
  } event_e;

  // One byte of the CRC-8, MSB first.
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ src/i2c_mailbox_slave_endpoint.sv @@
`default_nettype none
// Channel   | Signals                                           | Direction
// ----------+---------------------------------------------------+----------
// command   | start_i, busy_o, op_i, byte_in_i, first_i,        | in
//           | last_i, host_dest_i                               |
// result    | valid_o, event_res_o, byte_out_o, source_o,       | out
//           | length_o, final_res_o                             |
//
// A transfer is accepted when start_i is high and busy_o is low. Any transfer
// other than a poll read or a DELIVER frame of four bytes or more gives a single
// result, strobed in the cycle right after acceptance, and leaves busy_o low, so
// such transfers can follow back to back. A poll read holds busy_o high and
// strobes MSG_BYTES+3 results on consecutive cycles, paced by the queue memory
// read port. A DELIVER frame first runs its CRC over the frame memory (one
// priming read, then one byte a cycle); delivery, if the CRC matches, then takes
// one priming read and streams one byte a cycle, or gives a single result for a
// zero-length message. Each frame start clears the frame memory through a valid
// bit per slot. Reset clears all control state; the memories need no reset. The
// receiver cannot stall, so results are simply strobed out.
module i2c_mailbox_slave_endpoint #(
  parameter int MSG_BYTES   = imse_pkg::MsgBytesDefault,
  parameter int QUEUE_DEPTH = imse_pkg::QueueDepthDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  output logic            busy_o,
  input  wire logic [1:0] op_i,
  input  wire logic [7:0] byte_in_i,
  input  wire logic       first_i,
  input  wire logic       last_i,
  input  wire logic [7:0] host_dest_i,
  output logic            valid_o,
  output logic [3:0]      event_res_o,
  output logic [7:0]      byte_out_o,
  output logic [7:0]      source_o,
  output logic [5:0]      length_o,
  output logic            final_res_o
);
  import imse_pkg::*;

  localparam int FrameMax = MSG_BYTES + 3;
  localparam int FW  = $clog2(FrameMax + 2);
  localparam int FIW = $clog2(FrameMax);
  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int HW  = $clog2(MSG_BYTES + 1);
  localparam int QSlots = QUEUE_DEPTH * MSG_BYTES;
  localparam int AW  = (QSlots > 1) ? $clog2(QSlots) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CRC, S_DELIV, S_PLEN, S_POLL, S_POLLCRC
  } state_e;

  // Memories.
  logic [7:0] frame_mem [FrameMax];
  logic [7:0] queue_mem [QSlots];
  logic [7:0] qdest_mem [QUEUE_DEPTH];
  logic [5:0] qlen_mem  [QUEUE_DEPTH];
  logic [FrameMax-1:0] fvalid_q, fvalid_d;
  logic [7:0] frd_q, qrd_q;
  logic       frd_v_q;

  state_e        state_q;
  logic [QW-1:0] head_q, tail_q;
  logic [CW-1:0] count_q;
  pend_e         pend_q;
  logic [FW-1:0] fcount_q;
  logic [7:0]    fcmd_q;
  logic [7:0]    slot0_q;     // copy of frame slot 0, the ACK status
  logic [HW-1:0] hfill_q;
  logic [7:0]    htarget_q;
  logic          hblock_q;

  logic [FW-1:0] idx_q;       // sequencer position, also the read address
  logic [FW-1:0] lim_q;       // slot of the CRC byte
  logic [7:0]    crc_q;
  logic [7:0]    src_q;
  logic [5:0]    dlen_q;
  logic [7:0]    lenb_q;      // raw length byte

  logic        fire;
  assign busy_o = (state_q != S_IDLE);
  assign fire   = start_i && !busy_o;

  function automatic logic [QW-1:0] qinc(input logic [QW-1:0] p);
    return (32'(p) + 1 >= QUEUE_DEPTH) ? '0 : p + QW'(1);
  endfunction

  // Combinational control.
  logic           is_wr, is_host, newf, fwe, frd_en;
  logic [FW-1:0]  fc0, nfc;
  logic [FIW-1:0] fwa, fra;
  logic [7:0]     cmd, ack_st, htgt;
  logic           hnew, qfull, hblk, qwe, qhwe, qrd_en;
  logic [HW-1:0]  hf0, hf1;
  logic [AW-1:0]  qwa, qra;
  always_comb begin
    is_wr   = fire && (op_i == OP_WRITE);
    is_host = fire && (op_i == OP_HOST);
    // Bus frame bookkeeping.
    newf = first_i || (fcount_q == '0);
    fc0  = newf ? '0 : fcount_q;
    if (fc0 == '0) begin
      nfc = FW'(1);
    end else if (32'(fc0) < FrameMax + 1) begin
      nfc = fc0 + FW'(1);
    end else begin
      nfc = fc0;
    end
    cmd    = (fc0 == '0) ? byte_in_i : fcmd_q;
    fwe    = is_wr && (fc0 != '0) && (32'(fc0) <= FrameMax);
    fwa    = FIW'(fc0 - FW'(1));
    ack_st = (fwe && fwa == '0) ? byte_in_i : slot0_q;
    fvalid_d = fvalid_q;
    if (is_wr && newf) fvalid_d = '0;
    if (fwe) fvalid_d[fwa] = 1'b1;
    frd_en = ((state_q == S_CRC) || (state_q == S_DELIV)) && (32'(idx_q) < FrameMax);
    fra    = FIW'(idx_q);
    // Host message bookkeeping.
    hnew  = first_i || (hfill_q == '0);
    hf0   = hnew ? '0 : hfill_q;
    htgt  = hnew ? host_dest_i : htarget_q;
    qfull = (32'(count_q) >= QUEUE_DEPTH);
    hblk  = (!hnew && hblock_q) || qfull;
    hf1   = (32'(hf0) < MSG_BYTES) ? hf0 + HW'(1) : hf0;
    qwe   = is_host && !qfull && (32'(hf0) < MSG_BYTES);
    qwa   = AW'(32'(tail_q) * MSG_BYTES + 32'(hf0));
    qhwe  = is_host && last_i && !hblk;
    qrd_en = ((state_q == S_PLEN) || (state_q == S_POLL)) && (32'(idx_q) < MSG_BYTES);
    qra    = AW'(32'(head_q) * MSG_BYTES + 32'(idx_q));
  end

  // Frame memory and queue memory: one synchronous read per cycle each.
  always_ff @(posedge clk_i) begin
    if (fwe) frame_mem[fwa] <= byte_in_i;
    if (frd_en) frd_q <= frame_mem[fra];
    if (qwe) queue_mem[qwa] <= byte_in_i;
    if (qrd_en) qrd_q <= queue_mem[qra];
    if (qhwe) begin
      qdest_mem[tail_q] <= htgt;
      qlen_mem[tail_q]  <= 6'(hf1);
    end
  end

  logic [7:0] fbyte;
  assign fbyte = frd_v_q ? frd_q : 8'h00;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic [7:0] v;
    if (!rst_ni) begin
      state_q <= S_IDLE; head_q <= '0; tail_q <= '0; count_q <= '0;
      pend_q <= PEND_NONE; fcount_q <= '0; fcmd_q <= '0; slot0_q <= '0;
      hfill_q <= '0; htarget_q <= '0; hblock_q <= 1'b0; fvalid_q <= '0;
      valid_o <= 1'b0; frd_v_q <= 1'b0; idx_q <= '0; lim_q <= '0;
      crc_q <= '0; src_q <= '0; dlen_q <= '0; lenb_q <= '0;
      event_res_o <= '0; byte_out_o <= '0; source_o <= '0; length_o <= '0;
      final_res_o <= 1'b0;
    end else begin
      fvalid_q <= fvalid_d;
      if (frd_en) frd_v_q <= fvalid_q[fra];
      if (fwe && fwa == '0) slot0_q <= byte_in_i;
      valid_o <= 1'b0;
      event_res_o <= EV_TAKEN; byte_out_o <= '0; source_o <= '0;
      length_o <= '0; final_res_o <= 1'b1;
      case (state_q)
        S_IDLE: begin
          if (fire) begin
            valid_o <= 1'b1;
            case (op_i)
              OP_WRITE: begin
                if (fc0 == '0) fcmd_q <= byte_in_i;
                fcount_q <= last_i ? '0 : nfc;
                if (last_i) begin
                  if (cmd == CmdPoll) begin
                    pend_q <= PEND_POLL;
                  end else if (cmd == CmdDeliver) begin
                    if (32'(nfc) < 4) begin
                      event_res_o <= EV_IGNORED;
                    end else begin
                      // The frame count saturates, so the CRC byte is always
                      // the last stored slot.
                      valid_o <= 1'b0;
                      lim_q <= nfc - FW'(2);
                      idx_q <= '0;
                      crc_q <= '0;
                      state_q <= S_CRC;
                    end
                  end else if (cmd == CmdAck && 32'(nfc) >= 2) begin
                    pend_q <= PEND_ACK;
                    if (ack_st == AckGood) begin
                      event_res_o <= EV_ACKOK;
                      if (count_q != '0) begin
                        head_q <= qinc(head_q);
                        count_q <= count_q - CW'(1);
                      end
                    end else begin
                      event_res_o <= EV_NACK;
                    end
                  end else begin
                    event_res_o <= EV_IGNORED;
                  end
                end
              end
              OP_READ: begin
                pend_q <= PEND_NONE;
                event_res_o <= EV_READ;
                if (pend_q == PEND_POLL) begin
                  v = (count_q != '0) ? qdest_mem[head_q] : 8'h00;
                  byte_out_o <= v;
                  final_res_o <= 1'b0;
                  crc_q <= crc_step(8'h00, v);
                  if (count_q == '0) begin
                    dlen_q <= '0;
                  end else if (32'(qlen_mem[head_q]) > MSG_BYTES) begin
                    dlen_q <= 6'(MSG_BYTES);
                  end else begin
                    dlen_q <= qlen_mem[head_q];
                  end
                  idx_q <= '0;
                  state_q <= S_PLEN;
                end
              end
              OP_HOST: begin
                htarget_q <= htgt;
                if (!last_i) begin
                  hfill_q <= hf1; hblock_q <= hblk;
                end else begin
                  if (!hblk) begin
                    tail_q <= qinc(tail_q);
                    count_q <= count_q + CW'(1);
                    event_res_o <= EV_ACCEPT;
                  end else begin
                    event_res_o <= EV_REJECT;
                  end
                  hfill_q <= '0; hblock_q <= 1'b0;
                end
              end
              default: begin
                event_res_o <= EV_IGNORED;
              end
            endcase
          end
        end
        S_CRC: begin
          // idx_q addresses the read this cycle; data of slot idx_q-1 arrives now.
          if (idx_q == '0) begin
            idx_q <= FW'(1);
          end else if (idx_q - FW'(1) == lim_q) begin
            if (crc_q != fbyte) begin
              valid_o <= 1'b1;
              event_res_o <= EV_CRCERR;
              state_q <= S_IDLE;
            end else begin
              pend_q <= PEND_DELIVER;
              dlen_q <= (32'(lenb_q) > MSG_BYTES) ? 6'(MSG_BYTES) : 6'(lenb_q);
              idx_q <= FW'(2);
              state_q <= S_DELIV;
            end
          end else begin
            crc_q <= crc_step(crc_q, fbyte);
            if (idx_q == FW'(1)) src_q <= fbyte;
            if (idx_q == FW'(2)) lenb_q <= fbyte;
            idx_q <= idx_q + FW'(1);
          end
        end
        S_DELIV: begin
          // The message starts at slot 2; the first cycle only primes that read.
          if (dlen_q == '0) begin
            valid_o <= 1'b1;
            event_res_o <= EV_DELIV; source_o <= src_q;
            state_q <= S_IDLE;
          end else if (idx_q == FW'(2)) begin
            idx_q <= FW'(3);
          end else begin
            valid_o <= 1'b1;
            event_res_o <= EV_DELIV; byte_out_o <= fbyte;
            source_o <= src_q; length_o <= dlen_q;
            final_res_o <= (32'(idx_q) - 2 == 32'(dlen_q));
            if (32'(idx_q) - 2 == 32'(dlen_q)) state_q <= S_IDLE;
            else idx_q <= idx_q + FW'(1);
          end
        end
        S_PLEN: begin
          // Length byte goes out while slot 0 of the head message is read.
          valid_o <= 1'b1;
          event_res_o <= EV_READ; byte_out_o <= 8'(dlen_q); final_res_o <= 1'b0;
          crc_q <= crc_step(crc_q, 8'(dlen_q));
          idx_q <= FW'(1);
          state_q <= S_POLL;
        end
        S_POLL: begin
          // Data of slot idx_q-1 arrives now; slots past the length read zero.
          v = (32'(idx_q) - 1 < 32'(dlen_q)) ? qrd_q : 8'h00;
          valid_o <= 1'b1;
          event_res_o <= EV_READ; byte_out_o <= v; final_res_o <= 1'b0;
          crc_q <= crc_step(crc_q, v);
          if (32'(idx_q) == MSG_BYTES) state_q <= S_POLLCRC;
          else idx_q <= idx_q + FW'(1);
        end
        S_POLLCRC: begin
          valid_o <= 1'b1;
          event_res_o <= EV_READ; byte_out_o <= crc_q;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ sim/i2c_mailbox_slave_endpoint_test.sv @@
`default_nettype none
// Self-checking bench for the mailbox slave endpoint. A behavioral mirror of
// the endpoint predicts every result of each accepted command transfer, and a
// monitor compares the strobed results in order against those predictions.
module i2c_mailbox_slave_endpoint_test;
  import imse_pkg::*;

  localparam int MsgBytes   = MsgBytesDefault;
  localparam int QueueDepth = QueueDepthDefault;
  localparam int FrameMax   = MsgBytes + 3;

  typedef struct packed {
    logic [3:0] ev;
    logic [7:0] data;
    logic [7:0] src;
    logic [5:0] len;
    logic       fin;
  } mailbox_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic [1:0] op_i = OP_NONE;
  logic [7:0] byte_in_i = '0;
  logic first_i = 1'b0;
  logic last_i = 1'b0;
  logic [7:0] host_dest_i = '0;
  logic busy_o, valid_o, final_res_o;
  logic [3:0] event_res_o;
  logic [7:0] byte_out_o, source_o;
  logic [5:0] length_o;

  always #6 clk_i = ~clk_i;

  i2c_mailbox_slave_endpoint dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .op_i, .byte_in_i, .first_i, .last_i,
    .host_dest_i, .valid_o, .event_res_o, .byte_out_o, .source_o, .length_o,
    .final_res_o
  );

  // Mirror of the endpoint state.
  logic [7:0] msg_store [QueueDepth*MsgBytes];
  logic [7:0] msg_dest [QueueDepth];
  logic [5:0] msg_len [QueueDepth];
  int unsigned q_rd, q_wr, q_used;
  pend_e pending;
  logic [7:0] frm [FrameMax];
  int unsigned frm_cnt;
  logic [7:0] frm_cmd;
  int unsigned host_cnt;
  logic [7:0] host_to;
  bit host_full;

  mailbox_result_t expected_results [$];
  int errors = 0;

  function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ 8'h07) : (c << 1);
    return c;
  endfunction

  function automatic void push_result(input event_e ev, input logic [7:0] d,
                                      input logic [7:0] s, input logic [5:0] l,
                                      input logic f);
    expected_results.push_back('{ev, d, s, l, f});
  endfunction

  // Results of a frame that has just been closed by its last byte.
  function automatic void close_frame();
    int unsigned idx, n;
    logic [7:0] crc;
    if (frm_cmd == CmdPoll) begin
      pending = PEND_POLL;
      push_result(EV_TAKEN, 0, 0, 0, 1);
    end else if (frm_cmd == CmdDeliver) begin
      if (frm_cnt < 4) begin
        push_result(EV_IGNORED, 0, 0, 0, 1);
        return;
      end
      idx = frm_cnt - 1;
      if (idx > FrameMax) idx = FrameMax;
      crc = 0;
      for (int i = 0; i + 1 < idx; i++) crc = crc8(crc, frm[i]);
      if (crc != frm[idx-1]) begin
        push_result(EV_CRCERR, 0, 0, 0, 1);
        return;
      end
      n = frm[1] > MsgBytes ? MsgBytes : frm[1];
      pending = PEND_DELIVER;
      if (n == 0) push_result(EV_DELIV, 0, frm[0], 0, 1);
      for (int i = 0; i < n; i++)
        push_result(EV_DELIV, frm[2+i], frm[0], 6'(n), i + 1 == n);
    end else if (frm_cmd == CmdAck && frm_cnt >= 2) begin
      pending = PEND_ACK;
      if (frm[0] == AckGood) begin
        if (q_used > 0) begin
          q_rd = (q_rd + 1) % QueueDepth;
          q_used--;
        end
        push_result(EV_ACKOK, 0, 0, 0, 1);
      end else begin
        push_result(EV_NACK, 0, 0, 0, 1);
      end
    end else begin
      push_result(EV_IGNORED, 0, 0, 0, 1);
    end
  endfunction

  function automatic void predict_mailbox(input logic [1:0] op, input logic [7:0] b,
                                          input logic fst, input logic lst,
                                          input logic [7:0] hd);
    logic [7:0] crc, v;
    int unsigned n;
    bit have;
    pend_e was;
    case (op)
      OP_WRITE: begin
        if (fst || frm_cnt == 0) begin
          foreach (frm[i]) frm[i] = 0;
          frm_cnt = 0;
        end
        if (frm_cnt == 0) begin
          frm_cmd = b;
          frm_cnt = 1;
        end else begin
          if (frm_cnt - 1 < FrameMax) frm[frm_cnt-1] = b;
          if (frm_cnt < FrameMax + 1) frm_cnt++;
        end
        if (!lst) push_result(EV_TAKEN, 0, 0, 0, 1);
        else begin
          close_frame();
          frm_cnt = 0;
        end
      end
      OP_READ: begin
        was = pending;
        pending = PEND_NONE;
        if (was == PEND_POLL) begin
          have = q_used > 0;
          n = have ? (msg_len[q_rd] > MsgBytes ? MsgBytes : msg_len[q_rd]) : 0;
          v = have ? msg_dest[q_rd] : 0;
          crc = crc8(0, v);
          push_result(EV_READ, v, 0, 0, 0);
          crc = crc8(crc, n[7:0]);
          push_result(EV_READ, n[7:0], 0, 0, 0);
          for (int i = 0; i < MsgBytes; i++) begin
            v = (have && i < n) ? msg_store[q_rd*MsgBytes+i] : 0;
            crc = crc8(crc, v);
            push_result(EV_READ, v, 0, 0, 0);
          end
          push_result(EV_READ, crc, 0, 0, 1);
        end else begin
          push_result(EV_READ, 0, 0, 0, 1);
        end
      end
      OP_HOST: begin
        if (fst || host_cnt == 0) begin
          host_cnt = 0;
          host_to = hd;
          host_full = 0;
        end
        if (q_used >= QueueDepth) host_full = 1;
        else if (host_cnt < MsgBytes) msg_store[q_wr*MsgBytes+host_cnt] = b;
        if (host_cnt < MsgBytes) host_cnt++;
        if (!lst) push_result(EV_TAKEN, 0, 0, 0, 1);
        else begin
          if (!host_full && q_used < QueueDepth) begin
            msg_dest[q_wr] = host_to;
            msg_len[q_wr] = 6'(host_cnt);
            q_wr = (q_wr + 1) % QueueDepth;
            q_used++;
            push_result(EV_ACCEPT, 0, 0, 0, 1);
          end else begin
            push_result(EV_REJECT, 0, 0, 0, 1);
          end
          host_cnt = 0;
          host_full = 0;
        end
      end
      default: push_result(EV_IGNORED, 0, 0, 0, 1);
    endcase
  endfunction

  // Result monitor: every strobe must match the oldest prediction.
  always @(posedge clk_i) begin
    mailbox_result_t want;
    if (rst_ni && valid_o) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result event_res=%0d", event_res_o);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (event_res_o !== want.ev) begin
          $error("event_res expected %0d actual %0d", want.ev, event_res_o); errors++;
        end
        if (byte_out_o !== want.data) begin
          $error("byte_out expected %0h actual %0h", want.data, byte_out_o); errors++;
        end
        if (source_o !== want.src) begin
          $error("source expected %0h actual %0h", want.src, source_o); errors++;
        end
        if (length_o !== want.len) begin
          $error("length expected %0d actual %0d", want.len, length_o); errors++;
        end
        if (final_res_o !== want.fin) begin
          $error("final_res expected %0b actual %0b", want.fin, final_res_o); errors++;
        end
      end
    end
  end

  int burst_left = 0;

  // Sends one command transfer; the sender may idle between bursts of random length.
  task automatic send_command(input logic [1:0] op, input logic [7:0] b,
                              input logic fst, input logic lst,
                              input logic [7:0] hd);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
    burst_left--;
    start_i <= 1'b1;
    op_i <= op;
    byte_in_i <= b;
    first_i <= fst;
    last_i <= lst;
    host_dest_i <= hd;
    do @(posedge clk_i); while (busy_o);
    predict_mailbox(op, b, fst, lst, hd);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic host_message(input int unsigned n, input logic [7:0] dst);
    for (int i = 0; i < n; i++)
      send_command(OP_HOST, 8'($urandom), i == 0, i == n - 1, dst);
  endtask

  // Bus write frame: command, then the payload bytes; CRC appended if asked.
  task automatic bus_frame(input logic [7:0] cmd, input logic [7:0] body [$],
                           input bit add_crc);
    logic [7:0] crc;
    crc = 0;
    foreach (body[i]) crc = crc8(crc, body[i]);
    if (add_crc) body.push_back(crc);
    send_command(OP_WRITE, cmd, 1, body.size() == 0, 0);
    foreach (body[i]) send_command(OP_WRITE, body[i], 0, i == body.size() - 1, 0);
  endtask

  // A bad delivery carries a CRC byte with one bit flipped.
  task automatic deliver(input logic [7:0] src, input logic [7:0] n,
                         input int unsigned sent, input bit good);
    logic [7:0] body [$];
    logic [7:0] crc;
    body = '{src, n};
    for (int i = 0; i < sent; i++) body.push_back(8'($urandom));
    crc = 0;
    foreach (body[i]) crc = crc8(crc, body[i]);
    body.push_back(good ? crc : crc ^ 8'h01);
    bus_frame(CmdDeliver, body, 0);
  endtask

  task automatic test_directed();
    logic [7:0] b [$];
    send_command(OP_READ, 8'hff, 1, 1, 0);          // read without poll
    send_command(OP_NONE, 8'hff, 1, 1, 8'hff);      // unused op
    bus_frame(CmdPoll, b, 0);
    send_command(OP_READ, 0, 0, 0, 0);              // poll read, empty queue
    host_message(1, 8'h00);
    host_message(MsgBytes + 3, 8'hff);               // overlong host message
    host_message(5, 8'h5a);
    host_message(2, 8'ha5);
    host_message(3, 8'h11);                          // queue full: rejected
    bus_frame(CmdPoll, b, 0);
    send_command(OP_READ, 0, 1, 1, 0);
    b = '{AckGood};
    bus_frame(CmdAck, b, 0);
    b = '{8'h00};
    bus_frame(CmdAck, b, 0);                         // nack
    b = '{};
    bus_frame(CmdAck, b, 0);                         // short ack
    b = '{8'h01, 8'h02};
    bus_frame(CmdDeliver, b, 0);                     // short deliver
    bus_frame(8'h77, b, 0);                          // unknown command
    deliver(8'hff, 0, 0, 1);                         // zero length
    deliver(8'h00, 8'hff, MsgBytes + 4, 1);          // clamped, overlong frame
    deliver(8'h42, 10, 3, 1);                        // missing slots read zero
    b = '{8'h42, 8'h02, 8'h01, 8'h02, 8'h00};
    bus_frame(CmdDeliver, b, 0);                     // bad CRC
    send_command(OP_WRITE, 8'h10, 0, 0, 0);          // no frame open: starts one
    send_command(OP_WRITE, CmdPoll, 1, 1, 0);        // restart drops the open frame
    send_command(OP_HOST, 8'h33, 0, 1, 8'h99);       // no message open: starts one
  endtask

  task automatic test_pause();
    drain_results();                                 // sender waits for all results
  endtask

  task automatic test_random();
    logic [7:0] b [$];
    int unsigned k;
    for (int it = 0; it < 30; it++) begin
      k = $urandom_range(0, 9);
      case (k)
        0, 1: host_message($urandom_range(0, 3) == 0 ? $urandom_range(1, MsgBytes + 2)
                                                     : $urandom_range(1, 4), 8'($urandom));
        2, 3: begin
          b = '{};
          bus_frame(CmdPoll, b, 0);
          send_command(OP_READ, 8'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
        end
        4: begin
          b = '{$urandom_range(0, 3) != 0 ? AckGood : 8'($urandom)};
          bus_frame(CmdAck, b, 0);
        end
        5: deliver(8'($urandom), 8'($urandom_range(0, 6)), $urandom_range(0, 6),
                   $urandom_range(0, 3) != 0);
        default: send_command(2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                              8'($urandom));
      endcase
    end
  endtask

  initial begin
    q_rd = 0; q_wr = 0; q_used = 0; pending = PEND_NONE;
    frm_cnt = 0; frm_cmd = 0; host_cnt = 0; host_to = 0; host_full = 0;
    foreach (frm[i]) frm[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pause();
    test_random();
    drain_results();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire
